@@ sv/rc4s_pkg.sv @@
package rc4s_pkg;

    localparam int SBOX_DEPTH = 256;
    localparam int BYTE_W     = 8;
    localparam int DIGEST_W   = 128;
    localparam int BLOCK_W    = 512;

    localparam logic [31:0] MD5_A0 = 32'h67452301;
    localparam logic [31:0] MD5_B0 = 32'hefcdab89;
    localparam logic [31:0] MD5_C0 = 32'h98badcfe;
    localparam logic [31:0] MD5_D0 = 32'h10325476;

    localparam logic [31:0] MD5_K [64] = '{
        32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
        32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
        32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
        32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
        32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
        32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
        32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
        32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
        32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
        32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
        32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
        32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
        32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
        32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
        32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
        32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
    };

    localparam logic [4:0] MD5_S [16] = '{
        5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9, 5'd14, 5'd20,
        5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21
    };

    typedef enum logic [10:0] {
        ST_IDLE = 11'b00000000001,
        ST_HASH = 11'b00000000010,
        ST_FILL = 11'b00000000100,
        ST_KS_A = 11'b00000001000,
        ST_KS_B = 11'b00000010000,
        ST_KS_C = 11'b00000100000,
        ST_KS_D = 11'b00001000000,
        ST_PR_A = 11'b00010000000,
        ST_PR_B = 11'b00100000000,
        ST_PR_C = 11'b01000000000,
        ST_PR_D = 11'b10000000000
    } rc4s_state_t;

endpackage

@@ sv/rc4s_ram.sv @@
module rc4s_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // read returns the old contents on a same-address write
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ sv/rc4s_md5.sv @@
module rc4s_md5
    import rc4s_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [BLOCK_W-1:0]  block,
    output logic                done,
    output logic [DIGEST_W-1:0] digest
);

    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [5:0]  round_reg, round_next;
    logic [31:0] a_reg, a_next, b_reg, b_next, c_reg, c_next, d_reg, d_next;
    logic [31:0] f, sum, word;
    logic [3:0]  g;
    logic [63:0] dbl;

    // one round per cycle
    always_comb
    begin
        case (round_reg[5:4])
            2'd0:
            begin
                f = (b_reg & c_reg) | (~b_reg & d_reg);
                g = round_reg[3:0];
            end
            2'd1:
            begin
                f = (d_reg & b_reg) | (~d_reg & c_reg);
                g = 4'(5 * round_reg + 1);
            end
            2'd2:
            begin
                f = b_reg ^ c_reg ^ d_reg;
                g = 4'(3 * round_reg + 5);
            end
            default:
            begin
                f = c_reg ^ (b_reg | ~d_reg);
                g = 4'(7 * round_reg);
            end
        endcase
        word = block[32*g +: 32];
        sum  = a_reg + f + MD5_K[round_reg] + word;
        dbl  = {sum, sum} << MD5_S[{round_reg[5:4], round_reg[1:0]}];

        busy_next  = busy_reg;
        done_next  = 1'b0;
        round_next = round_reg;
        a_next     = a_reg;
        b_next     = b_reg;
        c_next     = c_reg;
        d_next     = d_reg;
        if (start)
        begin
            busy_next  = 1'b1;
            round_next = '0;
            a_next     = MD5_A0;
            b_next     = MD5_B0;
            c_next     = MD5_C0;
            d_next     = MD5_D0;
        end
        else if (busy_reg)
        begin
            a_next     = d_reg;
            d_next     = c_reg;
            c_next     = b_reg;
            b_next     = b_reg + dbl[63:32];
            round_next = round_reg + 6'd1;
            if (round_reg == 6'd63)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            round_reg <= '0;
        end
        else
        begin
            busy_reg  <= busy_next;
            done_reg  <= done_next;
            round_reg <= round_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg <= a_next;
        b_reg <= b_next;
        c_reg <= c_next;
        d_reg <= d_next;
    end

    assign done   = done_reg;
    assign digest = {d_reg + MD5_D0, c_reg + MD5_C0, b_reg + MD5_B0, a_reg + MD5_A0};

endmodule

@@ sv/object_rc4_stream_decrypt.sv @@
// per-object rc4 stream decryption with an md5-derived object key: each request
// carries one cipher byte with its object and generation numbers and first/last
// marks, and yields one plain byte. a request with first_byte set hashes the
// document key, object and generation bytes (64 md5 rounds, one per cycle),
// refills the 256-entry permutation memory and runs the key schedule (read,
// read, write, write for each entry) before its byte is decrypted. every byte
// is decrypted in steps: read, read, swap-write plus keystream read, write,
// serialized by the single read and write port of the permutation memory.
// document_key may only be written while the block is idle; cfg_ready is always
// high. the result sits in an output register so a stalled result does not
// block the request that follows it from being staged once it drains
module object_rc4_stream_decrypt
    import rc4s_pkg::*;
#(
    parameter int KEY_BYTES = 5
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [39:0] document_key,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [23:0] object_number,
    input  logic [15:0] generation_number,
    input  logic [7:0]  data_byte,
    input  logic        first_byte,
    input  logic        last_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  plain_byte,
    output logic        end_of_object
);

    localparam int MSG_LEN = KEY_BYTES + 5;
    localparam int KEY_LEN = (MSG_LEN > 16) ? 16 : MSG_LEN;
    localparam int KIDX_W  = $clog2(KEY_LEN);
    localparam int AW      = $clog2(SBOX_DEPTH);

    rc4s_state_t state_reg, state_next;

    logic [39:0]         doc_key_reg;
    logic [23:0]         obj_reg, obj_next;
    logic [15:0]         gen_reg, gen_next;
    logic [7:0]          data_reg, data_next;
    logic                last_reg, last_next;
    logic [DIGEST_W-1:0] digest_reg, digest_next;
    logic [AW-1:0]       i_reg, i_next, j_reg, j_next, t_reg, t_next;
    logic [7:0]          si_reg, si_next, sj_reg, sj_next;
    logic [KIDX_W-1:0]   kidx_reg, kidx_next;
    logic                out_valid_reg, out_valid_next;
    logic [7:0]          plain_reg, plain_next;
    logic                eoo_reg, eoo_next;

    logic                in_accept;
    logic                ram_we;
    logic [AW-1:0]       ram_waddr, ram_raddr, jn;
    logic [7:0]          ram_wdata, ram_rdata, key_byte, ks;
    logic                md5_start, md5_done;
    logic [DIGEST_W-1:0] md5_digest;
    logic [BLOCK_W-1:0]  block;

    // padded one-block key message, byte k in bits 8k+7..8k
    genvar k;
    generate
        for (k = 0; k < 64; k++)
        begin : g_msg
            if (k < KEY_BYTES)
            begin : g_key
                if (k < 5)
                begin : g_doc
                    assign block[8*k +: 8] = doc_key_reg[8*(4-k) +: 8];
                end
                else
                begin : g_zero
                    assign block[8*k +: 8] = 8'h00;
                end
            end
            else if (k < KEY_BYTES + 3)
            begin : g_obj
                assign block[8*k +: 8] = obj_reg[8*(k-KEY_BYTES) +: 8];
            end
            else if (k < MSG_LEN)
            begin : g_gen
                assign block[8*k +: 8] = gen_reg[8*(k-KEY_BYTES-3) +: 8];
            end
            else if (k == MSG_LEN)
            begin : g_pad
                assign block[8*k +: 8] = 8'h80;
            end
            else if (k == 56)
            begin : g_len
                assign block[8*k +: 8] = 8'(MSG_LEN * 8);
            end
            else
            begin : g_fill
                assign block[8*k +: 8] = 8'h00;
            end
        end
    endgenerate

    rc4s_md5 u_md5 (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (md5_start),
        .block  (block),
        .done   (md5_done),
        .digest (md5_digest)
    );

    // permutation table
    rc4s_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (SBOX_DEPTH)
    ) u_sbox (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign cfg_ready = 1'b1;
    // stage a new request only when idle and the result slot is free or draining
    assign in_stall  = !((state_reg == ST_IDLE) && (!out_valid_reg || !out_stall));
    assign in_accept = in_valid && !in_stall;
    assign key_byte  = digest_reg[8*kidx_reg +: 8];

    always_comb
    begin
        state_next     = state_reg;
        obj_next       = obj_reg;
        gen_next       = gen_reg;
        data_next      = data_reg;
        last_next      = last_reg;
        digest_next    = digest_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        t_next         = t_reg;
        si_next        = si_reg;
        sj_next        = sj_reg;
        kidx_next      = kidx_reg;
        out_valid_next = out_valid_reg;
        plain_next     = plain_reg;
        eoo_next       = eoo_reg;
        ram_we         = 1'b0;
        ram_waddr      = i_reg;
        ram_wdata      = ram_rdata;
        ram_raddr      = i_reg;
        md5_start      = 1'b0;
        jn             = j_reg;
        ks             = ram_rdata;

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    obj_next  = object_number;
                    gen_next  = generation_number;
                    data_next = data_byte;
                    last_next = last_byte;
                    if (first_byte)
                    begin
                        md5_start  = 1'b1;
                        state_next = ST_HASH;
                    end
                    else
                    begin
                        i_next     = i_reg + 8'd1;
                        state_next = ST_PR_A;
                    end
                end
            end
            ST_HASH:
            begin
                if (md5_done)
                begin
                    digest_next = md5_digest;
                    i_next      = '0;
                    state_next  = ST_FILL;
                end
            end
            ST_FILL:
            begin
                // identity permutation
                ram_we    = 1'b1;
                ram_wdata = i_reg;
                i_next    = i_reg + 8'd1;
                if (i_reg == 8'hff)
                begin
                    j_next     = '0;
                    kidx_next  = '0;
                    state_next = ST_KS_A;
                end
            end
            ST_KS_A:
            begin
                state_next = ST_KS_B;
            end
            ST_KS_B:
            begin
                si_next    = ram_rdata;
                jn         = j_reg + ram_rdata + key_byte;
                j_next     = jn;
                ram_raddr  = jn;
                state_next = ST_KS_C;
            end
            ST_KS_C:
            begin
                ram_we     = 1'b1;
                state_next = ST_KS_D;
            end
            ST_KS_D:
            begin
                ram_we    = 1'b1;
                ram_waddr = j_reg;
                ram_wdata = si_reg;
                kidx_next = (kidx_reg == KIDX_W'(KEY_LEN - 1)) ? '0 : kidx_reg + 1'b1;
                if (i_reg == 8'hff)
                begin
                    // keystream starts with both indices cleared, walk index pre-incremented
                    i_next     = 8'd1;
                    j_next     = '0;
                    state_next = ST_PR_A;
                end
                else
                begin
                    i_next     = i_reg + 8'd1;
                    state_next = ST_KS_A;
                end
            end
            ST_PR_A:
            begin
                state_next = ST_PR_B;
            end
            ST_PR_B:
            begin
                si_next    = ram_rdata;
                jn         = j_reg + ram_rdata;
                j_next     = jn;
                ram_raddr  = jn;
                state_next = ST_PR_C;
            end
            ST_PR_C:
            begin
                // write s[i] = s[j] while reading the keystream entry
                sj_next    = ram_rdata;
                ram_we     = 1'b1;
                t_next     = si_reg + ram_rdata;
                ram_raddr  = si_reg + ram_rdata;
                state_next = ST_PR_D;
            end
            ST_PR_D:
            begin
                ram_we    = 1'b1;
                ram_waddr = j_reg;
                ram_wdata = si_reg;
                // forward the swapped entries, the read saw them before the swap
                if (t_reg == i_reg)
                begin
                    ks = sj_reg;
                end
                else if (t_reg == j_reg)
                begin
                    ks = si_reg;
                end
                plain_next     = data_reg ^ ks;
                eoo_next       = last_reg;
                out_valid_next = 1'b1;
                i_next         = i_reg;
                state_next     = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            doc_key_reg   <= '0;
            i_reg         <= '0;
            j_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            i_reg         <= i_next;
            j_reg         <= j_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                doc_key_reg <= document_key;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        obj_reg    <= obj_next;
        gen_reg    <= gen_next;
        data_reg   <= data_next;
        last_reg   <= last_next;
        digest_reg <= digest_next;
        t_reg      <= t_next;
        si_reg     <= si_next;
        sj_reg     <= sj_next;
        kidx_reg   <= kidx_next;
        plain_reg  <= plain_next;
        eoo_reg    <= eoo_next;
    end

    assign out_valid     = out_valid_reg;
    assign plain_byte    = plain_reg;
    assign end_of_object = eoo_reg;

endmodule

@@ sv/rc4s_checker.sv @@
module rc4s_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_stall,
    input logic       out_valid,
    input logic       out_stall,
    input logic [7:0] plain_byte,
    input logic       end_of_object,
    input logic       cfg_ready
);

    // one request at a time: busy right after a request is taken
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("request taken while previous one in flight");

    // a result only rises after the input was stalled, as while a request is in flight
    a_result_needs_request: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("result without work");

    // a free input means the result slot is free or draining
    a_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
        !in_stall |-> (!out_valid || !out_stall))
        else $error("input open while result blocked");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=>
            (out_valid && $stable(plain_byte) && $stable(end_of_object)))
        else $error("stalled result changed");

    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_ready)
        else $error("config port not ready");

endmodule

bind object_rc4_stream_decrypt rc4s_checker u_rc4s_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .plain_byte    (plain_byte),
    .end_of_object (end_of_object),
    .cfg_ready     (cfg_ready)
);
